@@ design/c2c_pkg.sv @@
// c2c_pkg: shared constants, codes and arithmetic helpers for coordinate_to_cartesian
// no dependencies

package c2c_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 18;

    // angle constants in Q30
    localparam logic [63:0] TWO_PI_Q30   = 64'd6746518852;
    localparam logic [63:0] PI_Q30       = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam logic [63:0] INV_GAIN_Q30 = 64'd652032874;

    // coordinate system codes
    localparam logic [1:0] SYS_CART  = 2'd0;
    localparam logic [1:0] SYS_CYL   = 2'd1;
    localparam logic [1:0] SYS_SPH   = 2'd2;
    localparam logic [1:0] SYS_PARAB = 2'd3;

    // arctan(2^-i) in Q30
    function automatic logic [29:0] atan_q30(input int i);
        logic [29:0] v;
        case (i)
            0:  v = 30'd843314857;
            1:  v = 30'd497837829;
            2:  v = 30'd263043837;
            3:  v = 30'd133525159;
            4:  v = 30'd67021687;
            5:  v = 30'd33543516;
            6:  v = 30'd16775851;
            7:  v = 30'd8388437;
            8:  v = 30'd4194283;
            9:  v = 30'd2097149;
            10: v = 30'd1048576;
            11: v = 30'd524288;
            12: v = 30'd262144;
            13: v = 30'd131072;
            14: v = 30'd65536;
            15: v = 30'd32768;
            16: v = 30'd16384;
            17: v = 30'd8192;
            18: v = 30'd4096;
            19: v = 30'd2048;
            20: v = 30'd1024;
            21: v = 30'd512;
            22: v = 30'd256;
            23: v = 30'd128;
            24: v = 30'd64;
            25: v = 30'd32;
            26: v = 30'd16;
            27: v = 30'd8;
            28: v = 30'd4;
            29: v = 30'd2;
            30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // round half up, then floor shift
    function automatic logic signed [71:0] rnd(input logic signed [71:0] v, input int s);
        logic signed [71:0] h;
        h = 72'sd1 <<< (s - 1);
        return (v + h) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -72'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ design/coordinate_to_cartesian.sv @@
// coordinate_to_cartesian: curvilinear to Cartesian conversion, Q16.16 in and out
// depends on c2c_pkg (constants, arctan table, rounding and saturation)
//
//  channel   ports                                        direction
//  input     s_valid s_ready s_coord_first/second/third   in
//  result    m_valid m_ready m_cart_x/y/z                 out
//  config    cfg_wr_en cfg_wr_data (coord_system)         in
//
// one point enters per cycle while the pipe is not stalled; the pipe runs through NRED angle
// reduction steps (14 at Q16.16) and then the CORDIC stages
// the whole pipe advances together; when the output register holds an untaken result the
// pipe and s_ready stall, nothing is dropped or repeated
// synchronous active-low reset clears the valid bits and coord_system

module coordinate_to_cartesian #(
    parameter int FRAC_BITS     = c2c_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = c2c_pkg::CORDIC_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_coord_first,
    input  logic signed [31:0] s_coord_second,
    input  logic signed [31:0] s_coord_third,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_cart_x,
    output logic signed [31:0] m_cart_y,
    output logic signed [31:0] m_cart_z
);

    localparam int SH   = 30 - FRAC_BITS;
    localparam int ZW   = 32 + SH;
    localparam int KTOP = (ZW > 33) ? ZW - 33 : 0;
    localparam int NRED = KTOP + 1;
    localparam int RW   = ZW + 3;
    localparam int NC   = CORDIC_STAGES;
    localparam int LAST = NRED + NC + 2;
    localparam int AW   = 35;
    localparam int CW   = 34;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] d;
    } side_t;

    logic en;
    logic vout_reg;
    logic [1:0] coord_system_reg;

    side_t sd_reg  [0:LAST];
    logic  vld_reg [0:LAST];

    logic [RW-1:0] r1_reg [0:NRED];
    logic [RW-1:0] r2_reg [0:NRED];

    logic signed [CW-1:0] x1_reg [0:NC];
    logic signed [CW-1:0] y1_reg [0:NC];
    logic signed [AW-1:0] z1_reg [0:NC];
    logic signed [CW-1:0] x2_reg [0:NC];
    logic signed [CW-1:0] y2_reg [0:NC];
    logic signed [AW-1:0] z2_reg [0:NC];
    logic                 fl1_reg [0:NC];
    logic                 fl2_reg [0:NC];

    logic signed [CW-1:0] c1_reg, s1_reg, c2_reg, s2_reg;

    assign en      = !vout_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coord_system_reg <= c2c_pkg::SYS_CART;
        end else if (cfg_wr_en) begin
            coord_system_reg <= cfg_wr_data;
        end
    end

    // input stage: widen angles to Q30 and bias them nonnegative
    localparam logic [63:0] BIAS64 = c2c_pkg::TWO_PI_Q30 << KTOP;
    logic [RW-1:0] r1_in, r2_in;
    assign r1_in = RW'($signed(RW'(s_coord_second)) <<< SH) + BIAS64[RW-1:0];
    assign r2_in = RW'($signed(RW'(s_coord_third)) <<< SH) + BIAS64[RW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid && s_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= '{mode: coord_system_reg, a: s_coord_first, b: s_coord_second,
                           d: s_coord_third};
            r1_reg[0] <= r1_in;
            r2_reg[0] <= r2_in;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= LAST; k++) begin : g_side
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    sd_reg[k] <= sd_reg[k-1];
                end
            end
        end

        // modulo 2 pi, one conditional subtract per stage
        for (k = 1; k <= NRED; k++) begin : g_red
            localparam logic [63:0] CJ64 = c2c_pkg::TWO_PI_Q30 << (KTOP - k + 1);
            always_ff @(posedge aclk) begin
                if (en) begin
                    r1_reg[k] <= (r1_reg[k-1] >= CJ64[RW-1:0]) ?
                                 r1_reg[k-1] - CJ64[RW-1:0] : r1_reg[k-1];
                    r2_reg[k] <= (r2_reg[k-1] >= CJ64[RW-1:0]) ?
                                 r2_reg[k-1] - CJ64[RW-1:0] : r2_reg[k-1];
                end
            end
        end
    endgenerate

    // fold into [-pi/2, pi/2]
    localparam logic signed [AW-1:0] TPI = AW'(c2c_pkg::TWO_PI_Q30);
    localparam logic signed [AW-1:0] PI  = AW'(c2c_pkg::PI_Q30);
    localparam logic signed [AW-1:0] HPI = AW'(c2c_pkg::HALF_PI_Q30);

    logic signed [AW-1:0] w1, w2, f1, f2;
    logic                 fold1, fold2;

    always_comb begin
        w1 = $signed(AW'(r1_reg[NRED]));
        w2 = $signed(AW'(r2_reg[NRED]));
        if (w1 >= PI) w1 = w1 - TPI;
        if (w2 >= PI) w2 = w2 - TPI;
        fold1 = 1'b1;
        fold2 = 1'b1;
        if (w1 > HPI) begin
            f1 = w1 - PI;
        end else if (w1 < -HPI) begin
            f1 = w1 + PI;
        end else begin
            f1    = w1;
            fold1 = 1'b0;
        end
        if (w2 > HPI) begin
            f2 = w2 - PI;
        end else if (w2 < -HPI) begin
            f2 = w2 + PI;
        end else begin
            f2    = w2;
            fold2 = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg[0]  <= CW'(c2c_pkg::INV_GAIN_Q30);
            y1_reg[0]  <= '0;
            z1_reg[0]  <= f1;
            x2_reg[0]  <= CW'(c2c_pkg::INV_GAIN_Q30);
            y2_reg[0]  <= '0;
            z2_reg[0]  <= f2;
            fl1_reg[0] <= fold1;
            fl2_reg[0] <= fold2;
        end
    end

    genvar i;
    generate
        for (i = 0; i < NC; i++) begin : g_cordic
            localparam logic signed [AW-1:0] ATN = AW'(c2c_pkg::atan_q30(i));
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (z1_reg[i] >= 0) begin
                        x1_reg[i+1] <= x1_reg[i] - (y1_reg[i] >>> i);
                        y1_reg[i+1] <= y1_reg[i] + (x1_reg[i] >>> i);
                        z1_reg[i+1] <= z1_reg[i] - ATN;
                    end else begin
                        x1_reg[i+1] <= x1_reg[i] + (y1_reg[i] >>> i);
                        y1_reg[i+1] <= y1_reg[i] - (x1_reg[i] >>> i);
                        z1_reg[i+1] <= z1_reg[i] + ATN;
                    end
                    if (z2_reg[i] >= 0) begin
                        x2_reg[i+1] <= x2_reg[i] - (y2_reg[i] >>> i);
                        y2_reg[i+1] <= y2_reg[i] + (x2_reg[i] >>> i);
                        z2_reg[i+1] <= z2_reg[i] - ATN;
                    end else begin
                        x2_reg[i+1] <= x2_reg[i] + (y2_reg[i] >>> i);
                        y2_reg[i+1] <= y2_reg[i] - (x2_reg[i] >>> i);
                        z2_reg[i+1] <= z2_reg[i] + ATN;
                    end
                    fl1_reg[i+1] <= fl1_reg[i];
                    fl2_reg[i+1] <= fl2_reg[i];
                end
            end
        end
    endgenerate

    // undo the fold
    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg <= fl1_reg[NC] ? -x1_reg[NC] : x1_reg[NC];
            s1_reg <= fl1_reg[NC] ? -y1_reg[NC] : y1_reg[NC];
            c2_reg <= fl2_reg[NC] ? -x2_reg[NC] : x2_reg[NC];
            s2_reg <= fl2_reg[NC] ? -y2_reg[NC] : y2_reg[NC];
        end
    end

    // first products
    logic                 v1_reg;
    side_t                p1_sd_reg;
    logic signed [71:0]   pac1_reg, pas1_reg, pac2_reg, pas2_reg, pbb_reg, paa_reg;
    logic signed [CW-1:0] p1_c2_reg, p1_s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_sd_reg <= sd_reg[LAST];
            pac1_reg  <= 72'(sd_reg[LAST].a * c1_reg);
            pas1_reg  <= 72'(sd_reg[LAST].a * s1_reg);
            pac2_reg  <= 72'(sd_reg[LAST].a * c2_reg);
            pas2_reg  <= 72'(sd_reg[LAST].a * s2_reg);
            pbb_reg   <= 72'(sd_reg[LAST].b * sd_reg[LAST].b);
            paa_reg   <= 72'(sd_reg[LAST].a * sd_reg[LAST].a);
            p1_c2_reg <= c2_reg;
            p1_s2_reg <= s2_reg;
        end
    end

    // rounding of first products
    logic                 v2_reg;
    side_t                p2_sd_reg;
    logic signed [36:0]   m_reg, p_reg, q_reg;
    logic signed [71:0]   xc1_reg, zp_reg;
    logic signed [CW-1:0] p2_c2_reg, p2_s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_sd_reg <= p1_sd_reg;
            m_reg     <= 37'(c2c_pkg::rnd(pas1_reg, 30));
            p_reg     <= 37'(c2c_pkg::rnd(pac2_reg, 30));
            q_reg     <= 37'(c2c_pkg::rnd(pas2_reg, 30));
            xc1_reg   <= c2c_pkg::rnd(pac1_reg, 30);
            zp_reg    <= c2c_pkg::rnd(pbb_reg - paa_reg, FRAC_BITS + 1);
            p2_c2_reg <= p1_c2_reg;
            p2_s2_reg <= p1_s2_reg;
        end
    end

    // second products, shared between spherical and parabolic
    logic                 v3_reg;
    side_t                p3_sd_reg;
    logic signed [71:0]   px_reg, py_reg, p3_xc1_reg, p3_zp_reg, p3_m_reg;
    logic signed [36:0]   opx_a, opy_a;
    logic signed [CW-1:0] opx_b, opy_b;
    logic                 parab;

    assign parab = (p2_sd_reg.mode == c2c_pkg::SYS_PARAB);
    assign opx_a = parab ? p_reg : m_reg;
    assign opy_a = parab ? q_reg : m_reg;
    assign opx_b = parab ? CW'(p2_sd_reg.b) : p2_c2_reg;
    assign opy_b = parab ? CW'(p2_sd_reg.b) : p2_s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_sd_reg  <= p2_sd_reg;
            px_reg     <= 72'(opx_a * opx_b);
            py_reg     <= 72'(opy_a * opy_b);
            p3_xc1_reg <= xc1_reg;
            p3_zp_reg  <= zp_reg;
            p3_m_reg   <= 72'(m_reg);
        end
    end

    // final rounding, select and saturate
    logic signed [71:0] fx, fy, fz;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;

    always_comb begin
        unique case (p3_sd_reg.mode)
            c2c_pkg::SYS_CYL: begin
                fx = p3_xc1_reg;
                fy = p3_m_reg;
                fz = 72'(p3_sd_reg.d);
            end
            c2c_pkg::SYS_SPH: begin
                fx = c2c_pkg::rnd(px_reg, 30);
                fy = c2c_pkg::rnd(py_reg, 30);
                fz = p3_xc1_reg;
            end
            c2c_pkg::SYS_PARAB: begin
                fx = c2c_pkg::rnd(px_reg, FRAC_BITS);
                fy = c2c_pkg::rnd(py_reg, FRAC_BITS);
                fz = p3_zp_reg;
            end
            default: begin
                fx = 72'(p3_sd_reg.a);
                fy = 72'(p3_sd_reg.b);
                fz = 72'(p3_sd_reg.d);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vout_reg <= 1'b0;
        end else if (en) begin
            vout_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ox_reg <= c2c_pkg::sat32(fx);
            oy_reg <= c2c_pkg::sat32(fy);
            oz_reg <= c2c_pkg::sat32(fz);
        end
    end

    assign m_valid  = vout_reg;
    assign m_cart_x = ox_reg;
    assign m_cart_y = oy_reg;
    assign m_cart_z = oz_reg;

endmodule

@@ bench/coordinate_to_cartesian_tb.sv @@
// coordinate_to_cartesian_tb: self-checking bench for the coordinate converter
// depends on c2c_pkg and coordinate_to_cartesian
`timescale 1ns / 1ps

module coordinate_to_cartesian_tb;

    localparam int FRAC = 16;
    localparam int STAGES = 18;
    localparam int LATENCY = 14 + STAGES + 7;
    localparam int STALL_LIMIT = 20000;

    localparam longint PI_L = 64'sd3373259426;
    localparam longint TWO_PI_L = 64'sd6746518852;
    localparam longint HALF_PI_L = 64'sd1686629713;
    localparam longint INV_GAIN_L = 64'sd652032874;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } cart_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_coord_first = '0;
    logic signed [31:0] s_coord_second = '0;
    logic signed [31:0] s_coord_third = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_cart_x, m_cart_y, m_cart_z;

    coordinate_to_cartesian dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_coord_first(s_coord_first), .s_coord_second(s_coord_second),
        .s_coord_third(s_coord_third),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_cart_x(m_cart_x), .m_cart_y(m_cart_y), .m_cart_z(m_cart_z)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    logic [1:0] coord_sys_model = c2c_pkg::SYS_CART;
    cart_t expected_points[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;

    longint atan_tab[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2,
        1, 0};

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // cosine and sine in Q30 via rotation-mode cordic after folding into [-pi/2, pi/2]
    task automatic cordic_sincos(input longint ang, output longint c, output longint s);
        longint z, x, y, nx;
        bit flip;
        z = ang * (64'sd1 <<< (30 - FRAC));
        x = INV_GAIN_L;
        y = 0;
        flip = 1'b0;
        z = z % TWO_PI_L;
        if (z < 0) z += TWO_PI_L;
        if (z >= PI_L) z -= TWO_PI_L;
        if (z > HALF_PI_L) begin
            z -= PI_L;
            flip = 1'b1;
        end else if (z < -HALF_PI_L) begin
            z += PI_L;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_tab[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_tab[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_cartesian(input logic signed [31:0] f, input logic signed [31:0] g,
                                     input logic signed [31:0] h, output cart_t r);
        longint a, b, d, c1, s1, c2, s2, m;
        a = f;
        b = g;
        d = h;
        case (coord_sys_model)
            c2c_pkg::SYS_CYL: begin
                cordic_sincos(b, c1, s1);
                r.x = clamp32(round_shift(a * c1, 30));
                r.y = clamp32(round_shift(a * s1, 30));
                r.z = clamp32(d);
            end
            c2c_pkg::SYS_SPH: begin
                cordic_sincos(b, c1, s1);
                cordic_sincos(d, c2, s2);
                m = round_shift(a * s1, 30);
                r.x = clamp32(round_shift(m * c2, 30));
                r.y = clamp32(round_shift(m * s2, 30));
                r.z = clamp32(round_shift(a * c1, 30));
            end
            c2c_pkg::SYS_PARAB: begin
                cordic_sincos(d, c2, s2);
                r.x = clamp32(round_shift(round_shift(a * c2, 30) * b, FRAC));
                r.y = clamp32(round_shift(round_shift(a * s2, 30) * b, FRAC));
                r.z = clamp32(round_shift(b * b - a * a, FRAC + 1));
            end
            default: begin
                r.x = f;
                r.y = g;
                r.z = h;
            end
        endcase
    endtask

    // valid stays high across back-to-back transactions, drops only while idling
    task automatic send_point(input logic [31:0] f, input logic [31:0] g, input logic [31:0] h);
        cart_t e;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_coord_first <= f;
        s_coord_second <= g;
        s_coord_third <= h;
        predict_cartesian(f, g, h, e);
        expected_points.push_back(e);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // receiver stalls at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cart_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction x=%0d", m_cart_x);
            end else begin
                e = expected_points.pop_front();
                if (m_cart_x !== e.x || m_cart_y !== e.y || m_cart_z !== e.z) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch sys=%0d exp (%0d %0d %0d) got (%0d %0d %0d)",
                                 coord_sys_model, e.x, e.y, e.z, m_cart_x, m_cart_y, m_cart_z);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            timed_out = 1'b1;
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic drain_pipe;
        s_valid <= 1'b0;
        while (expected_points.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic set_coord_system(input logic [1:0] sys);
        drain_pipe();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= sys;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        coord_sys_model = sys;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h7fffffff - $urandom_range(3);
            2: return 32'h80000000 + $urandom_range(3);
            3: return $urandom_range(16'hffff) - 32'd32768;
            default: return {{12{$urandom_range(1) == 1}}, 20'($urandom())};
        endcase
    endfunction

    function automatic logic [31:0] rand_angle();
        if ($urandom_range(3) == 0) return $urandom();
        return 32'($urandom_range(823550)) - 32'd411775; // about [-2pi, 2pi]
    endfunction

    task automatic test_directed(input logic [1:0] sys);
        logic [31:0] edges[6] = '{32'h0, 32'h1, 32'hffffffff, 32'h7fffffff,
                                   32'h80000000, 32'h00010000};
        set_coord_system(sys);
        foreach (edges[i]) send_point(edges[i], edges[(i + 2) % 6], edges[5 - i]);
        // angles on quadrant edges, near pi and at pi/4
        send_point(32'h00010000, 32'd102944, 32'd205887);
        send_point(32'h00010000, -32'd102944, 32'd51472);
    endtask

    task automatic test_random_mix(input int n);
        logic [1:0] sys;
        for (int k = 0; k < n; k++) begin
            if (k % 60 == 0) begin
                sys = 2'($urandom_range(3));
                set_coord_system(sys);
            end
            send_point(rand_word(), rand_angle(), rand_angle());
        end
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed(c2c_pkg::SYS_CART);
        test_directed(c2c_pkg::SYS_CYL);
        test_directed(c2c_pkg::SYS_SPH);
        test_directed(c2c_pkg::SYS_PARAB);
        send_idle_pct = 28;
        recv_idle_pct = 55;
        test_random_mix(300);
        send_idle_pct = 55;
        recv_idle_pct = 28;
        test_random_mix(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(300);
        set_coord_system(c2c_pkg::SYS_CART);
        if (mismatches == 0 && expected_points.size() == 0 && !timed_out) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
